>>> rtl/sma_pkg.sv
package sma_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W = 9;
  localparam int SUM_W = SAMPLE_W + WIN_W;
  localparam int DEF_MAX_WINDOW = 256;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);
  localparam int QUEUE_DEPTH = 2;

  // one division request: window sum and the divisor in force for it
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [WIN_W-1:0]        win;
  } req_t;

endpackage

>>> rtl/sma_ram.sv
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/sma_queue.sv
module sma_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sma_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output sma_pkg::req_t pop_data,
  output logic          empty
);

  localparam int QW = $clog2(sma_pkg::QUEUE_DEPTH);

  sma_pkg::req_t slots [sma_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wp;
  logic [QW-1:0] rp;
  logic [QW:0]   cnt;

  assign full = cnt == (QW + 1)'(sma_pkg::QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= rp + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt <= cnt + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("request popped from empty queue");

endmodule

>>> rtl/sma_front.sv
module sma_front #(
  parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sma_pkg::WIN_W-1:0]    cfg_wdata,
  input  logic [sma_pkg::SAMPLE_W-1:0] sample,
  input  logic                         series_start,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         push,
  output sma_pkg::req_t                push_data,
  input  logic                         full
);

  localparam int PTR_W = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int WREG_MAX = (1 << sma_pkg::WIN_W) - 1;
  localparam int WMAX = MAX_WINDOW > WREG_MAX ? WREG_MAX : MAX_WINDOW;
  localparam logic [sma_pkg::WIN_W-1:0] WMAX_V = sma_pkg::WIN_W'(WMAX);
  localparam int EW = (PTR_W > sma_pkg::WIN_W ? PTR_W : sma_pkg::WIN_W) + 2;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(MAX_WINDOW - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_PUSH = 3'b100
  } state_t;

  state_t state;

  logic [sma_pkg::WIN_W-1:0]        window_reg;
  logic [sma_pkg::WIN_W-1:0]        w;
  logic [sma_pkg::WIN_W-1:0]        fill;
  logic [sma_pkg::WIN_W-1:0]        fill_eff;
  logic [sma_pkg::WIN_W-1:0]        fill_next;
  logic [PTR_W-1:0]                 pos;
  logic [PTR_W-1:0]                 pos_next;
  logic [PTR_W-1:0]                 old_addr;
  logic [EW-1:0]                    old_e;
  logic signed [sma_pkg::SUM_W-1:0] total;
  logic signed [sma_pkg::SUM_W-1:0] total_next;
  logic signed [sma_pkg::SUM_W-1:0] base;
  logic signed [sma_pkg::SUM_W-1:0] sub_val;
  logic signed [sma_pkg::SUM_W-1:0] smp_ext;
  logic [sma_pkg::SAMPLE_W-1:0]     smp;
  logic [sma_pkg::SAMPLE_W-1:0]     rd_data;
  logic                             need_sub;
  logic                             produce;
  logic                             accept;

  always_comb begin
    if (window_reg == '0) begin
      w = sma_pkg::WIN_W'(1);
    end else if (window_reg > WMAX_V) begin
      w = WMAX_V;
    end else begin
      w = window_reg;
    end
  end

  assign in_stall = state != F_IDLE;
  assign accept = in_valid && (state == F_IDLE);
  assign push = (state == F_PUSH) && !full;

  assign fill_eff = series_start ? '0 : fill;
  assign fill_next = (fill_eff < w) ? fill_eff + 1'b1 : fill_eff;

  // slot that drops out of the window
  always_comb begin
    old_e = EW'(pos) + MAX_E - EW'(w);
    if (old_e >= MAX_E) begin
      old_e = old_e - MAX_E;
    end
  end
  assign old_addr = old_e[PTR_W-1:0];

  assign pos_next = (pos == LAST_POS) ? '0 : pos + 1'b1;

  assign smp_ext = {{sma_pkg::WIN_W{smp[sma_pkg::SAMPLE_W-1]}}, smp};
  assign sub_val = need_sub ? {{sma_pkg::WIN_W{rd_data[sma_pkg::SAMPLE_W-1]}}, rd_data} : '0;
  assign total_next = base - sub_val + smp_ext;

  sma_ram #(
    .WIDTH (sma_pkg::SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_history (
    .clk     (clk),
    .wr_en   (state == F_READ),
    .wr_addr (pos),
    .wr_data (smp),
    .rd_en   (accept),
    .rd_addr (old_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      window_reg <= sma_pkg::WINDOW_RESET;
      fill <= '0;
      total <= '0;
      pos <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            smp <= sample;
            base <= series_start ? '0 : total;
            need_sub <= fill_eff >= w;
            produce <= fill_next >= w;
            fill <= fill_next;
            state <= F_READ;
          end
        end
        F_READ: begin
          total <= total_next;
          pos <= pos_next;
          push_data.sum <= total_next;
          push_data.win <= w;
          state <= produce ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
      if (cfg_we) begin
        window_reg <= cfg_wdata;
        fill <= '0;
        total <= '0;
      end
    end
  end

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == F_READ) |-> $past(accept))
    else $error("history read state entered without a request");

endmodule

>>> rtl/sma_back.sv
module sma_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  sma_pkg::req_t                pop_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sma_pkg::SAMPLE_W-1:0] average
);

  localparam int CW = $clog2(sma_pkg::SUM_W + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(sma_pkg::SUM_W - 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_DONE = 3'b100
  } state_t;

  state_t state;

  logic [sma_pkg::SUM_W-1:0] dvd;
  logic [sma_pkg::SUM_W-1:0] quo_signed;
  logic [sma_pkg::WIN_W-1:0] rem;
  logic [sma_pkg::WIN_W-1:0] div;
  logic [sma_pkg::WIN_W:0]   trial;
  logic                      ge;
  logic                      neg;
  logic [CW-1:0]             cnt;
  logic                      slot_free;

  assign pop = (state == B_IDLE) && !empty;
  assign slot_free = !out_valid || !out_stall;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dvd[sma_pkg::SUM_W-1]};
  assign ge = trial >= {1'b0, div};
  assign quo_signed = neg ? ~dvd + 1'b1 : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if ((state == B_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            neg <= pop_data.sum[sma_pkg::SUM_W-1];
            dvd <= pop_data.sum[sma_pkg::SUM_W-1] ? ~pop_data.sum + 1'b1 : pop_data.sum;
            div <= pop_data.win;
            rem <= '0;
            cnt <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          rem <= ge ? sma_pkg::WIN_W'(trial - {1'b0, div}) : trial[sma_pkg::WIN_W-1:0];
          dvd <= {dvd[sma_pkg::SUM_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (slot_free) begin
            average <= quo_signed[sma_pkg::SAMPLE_W-1:0];
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (div != '0))
    else $error("division with zero divisor");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (cnt <= LAST_STEP))
    else $error("divider ran past its last step");

endmodule

>>> rtl/simple_moving_average_core.sv
// Boxcar moving average over signed Q15.16 samples.
// Input channel: sample, series_start, in_valid / in_stall. A request is
// taken when in_valid is high and in_stall low; series_start begins a new
// series. Output channel: average, out_valid / out_stall, held while stalled.
// Config: cfg_we / cfg_wdata write the window length (0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW) and restart the series. Write only
// while no request is in flight.
// A result appears once the current series holds a full window.
// Front end takes one request at a time and holds in_stall high until done:
// history RAM read, then sum update, then push into a 2-entry queue when the
// request yields a result. Back end divides one bit per cycle: 41 steps plus
// load and output; it pops the next request only once the last result has
// moved into the output register.
// Reset: window 4, empty series, queue empty, no output valid; history RAM is
// not cleared and needs no clearing pass.
// When out_stall holds, the finished result waits in the output register,
// the divider holds its next quotient, and the queue and front end fill up;
// in_stall, high whenever the front end is busy, then stays high.
module simple_moving_average_core #(
  parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sma_pkg::WIN_W-1:0]    cfg_wdata,
  input  logic [sma_pkg::SAMPLE_W-1:0] sample,
  input  logic                         series_start,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic [sma_pkg::SAMPLE_W-1:0] average,
  output logic                         out_valid,
  input  logic                         out_stall
);

  sma_pkg::req_t push_data;
  sma_pkg::req_t pop_data;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  sma_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample       (sample),
    .series_start (series_start),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  sma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

endmodule
